// File: rtl/humidity_sensor_frame_decoder_assert.svh
// assertion macros shared by the decoder checkers
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, idle while rst_n is low
`define HSFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, idle while rst_n is low
`define HSFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hsfd_pkg.sv
// types, constants and the crc-8 step shared by the frame decoder
package hsfd_pkg;

  typedef logic        [7:0]  hsfd_byte_t;
  typedef logic        [15:0] hsfd_word_t;
  typedef logic signed [7:0]  hsfd_offset_t;
  typedef logic signed [14:0] hsfd_centi_t;
  typedef logic        [2:0]  hsfd_status_t;

  localparam hsfd_byte_t CRC_POLY = 8'h31;
  localparam hsfd_byte_t CRC_INIT = 8'hFF;

  localparam hsfd_status_t STATUS_OK         = 3'd0;
  localparam hsfd_status_t STATUS_TEMP_CRC   = 3'd1;
  localparam hsfd_status_t STATUS_HUM_CRC    = 3'd2;
  localparam hsfd_status_t STATUS_TEMP_RANGE = 3'd3;
  localparam hsfd_status_t STATUS_HUM_RANGE  = 3'd4;

  localparam logic signed [15:0] TEMP_MIN = -16'sd4000;
  localparam logic signed [15:0] TEMP_MAX = 16'sd12500;
  localparam logic signed [15:0] HUM_MIN  = 16'sd0;
  localparam logic signed [15:0] HUM_MAX  = 16'sd10000;

  // one complete frame handed from the parser to the conversion pipeline
  typedef struct packed {
    hsfd_word_t temp_word;
    hsfd_word_t hum_word;
    logic       temp_crc_good;
    logic       hum_crc_good;
  } hsfd_frame_t;

  function automatic hsfd_byte_t crc8_update(input hsfd_byte_t crc, input hsfd_byte_t data);
    hsfd_byte_t c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/hsfd_if.sv
// channel interfaces: byte input, result output, configuration write
interface hsfd_in_if import hsfd_pkg::*; ();
  logic       valid;
  logic       ready;
  hsfd_byte_t rx_byte;
  logic       frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface hsfd_out_if import hsfd_pkg::*; ();
  logic         valid;
  logic         ready;
  hsfd_centi_t  temperature_centi;
  hsfd_centi_t  humidity_centi;
  hsfd_status_t status;

  modport source (output valid, temperature_centi, humidity_centi, status, input ready);
  modport sink   (input valid, temperature_centi, humidity_centi, status, output ready);
endinterface

interface hsfd_cfg_if import hsfd_pkg::*; ();
  logic         valid;
  logic         ready;
  hsfd_offset_t temp_offset;

  modport source (output valid, temp_offset, input ready);
  modport sink   (input valid, temp_offset, output ready);
endinterface

// File: rtl/humidity_sensor_frame_decoder.sv
// top level of the six-byte temperature/humidity frame decoder
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    rx_byte, frame_start
//   out_ch   out  valid / ready    temperature_centi, humidity_centi, status
//   cfg_ch   in   valid / ready    temp_offset
//
// one byte transaction per cycle while in_ready is high; the sixth byte of a frame
// yields a result through the frame register, then numerator, quotient and result stages
// rst_n is synchronous: byte position 0, crc 0xff, offset 0, pipeline empty
// a held result stalls the pipeline stage by stage; in_ready drops only when
// the frame register behind the parser cannot move
module humidity_sensor_frame_decoder import hsfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  hsfd_in_if.sink    in_ch,
  hsfd_out_if.source out_ch,
  hsfd_cfg_if.sink   cfg_ch
);

  hsfd_offset_t temp_offset_r;
  logic         frm_valid;
  logic         frm_ready;
  hsfd_frame_t  frm;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_offset_r <= '0;
    end else if (cfg_ch.valid) begin
      temp_offset_r <= cfg_ch.temp_offset;
    end
  end

  hsfd_frame_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (in_ch.valid),
    .byte_ready  (in_ch.ready),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .frm_valid   (frm_valid),
    .frm_ready   (frm_ready),
    .frm         (frm)
  );

  hsfd_convert u_convert (
    .clk               (clk),
    .rst_n             (rst_n),
    .frm_valid         (frm_valid),
    .frm_ready         (frm_ready),
    .frm               (frm),
    .temp_offset       (temp_offset_r),
    .res_valid         (out_ch.valid),
    .res_ready         (out_ch.ready),
    .temperature_centi (out_ch.temperature_centi),
    .humidity_centi    (out_ch.humidity_centi),
    .status            (out_ch.status)
  );

endmodule

// File: rtl/hsfd_frame_parser.sv
// byte position tracking, word capture and crc checks for one frame
module hsfd_frame_parser import hsfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  hsfd_byte_t  rx_byte,
  input  logic        frame_start,
  output logic        frm_valid,
  input  logic        frm_ready,
  output hsfd_frame_t frm
);

  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  logic [2:0]  byte_index_r, byte_index_nxt;
  hsfd_byte_t  crc_r, crc_nxt;
  hsfd_word_t  temp_word_r, temp_word_nxt;
  hsfd_word_t  hum_word_r, hum_word_nxt;
  logic        temp_crc_good_r, temp_crc_good_nxt;
  logic        frm_valid_r, frm_valid_nxt;
  hsfd_frame_t frm_r, frm_nxt;

  logic        accept;
  logic        frm_free;
  logic [2:0]  pos;
  hsfd_byte_t  crc_step;

  assign frm_free   = !frm_valid_r || frm_ready;
  assign byte_ready = frm_free;
  assign accept     = byte_valid && frm_free;
  assign frm_valid  = frm_valid_r;
  assign frm        = frm_r;

  always_comb begin
    pos = frame_start ? POS_TEMP_HI : byte_index_r;
    if (pos > POS_HUM_CRC) begin
      pos = POS_TEMP_HI;
    end
  end

  // both crc words restart from the initial value at their high byte
  assign crc_step = crc8_update(((pos == POS_TEMP_HI) || (pos == POS_HUM_HI)) ? CRC_INIT : crc_r,
                                rx_byte);

  always_comb begin
    byte_index_nxt    = byte_index_r;
    crc_nxt           = crc_r;
    temp_word_nxt     = temp_word_r;
    hum_word_nxt      = hum_word_r;
    temp_crc_good_nxt = temp_crc_good_r;
    frm_valid_nxt     = frm_free ? 1'b0 : frm_valid_r;
    frm_nxt           = frm_r;
    if (accept) begin
      byte_index_nxt = (pos == POS_HUM_CRC) ? POS_TEMP_HI : pos + 3'd1;
      case (pos)
        POS_TEMP_HI: begin
          temp_word_nxt = {rx_byte, 8'h00};
          crc_nxt       = crc_step;
        end
        POS_TEMP_LO: begin
          temp_word_nxt = {temp_word_r[15:8], rx_byte};
          crc_nxt       = crc_step;
        end
        POS_TEMP_CRC: begin
          temp_crc_good_nxt = (crc_r == rx_byte);
        end
        POS_HUM_HI: begin
          hum_word_nxt = {rx_byte, 8'h00};
          crc_nxt      = crc_step;
        end
        POS_HUM_LO: begin
          hum_word_nxt = {hum_word_r[15:8], rx_byte};
          crc_nxt      = crc_step;
        end
        default: begin
          frm_valid_nxt         = 1'b1;
          frm_nxt.temp_word     = temp_word_r;
          frm_nxt.hum_word      = hum_word_r;
          frm_nxt.temp_crc_good = temp_crc_good_r;
          frm_nxt.hum_crc_good  = (crc_r == rx_byte);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r    <= POS_TEMP_HI;
      crc_r           <= CRC_INIT;
      temp_word_r     <= '0;
      hum_word_r      <= '0;
      temp_crc_good_r <= 1'b0;
      frm_valid_r     <= 1'b0;
    end else begin
      byte_index_r    <= byte_index_nxt;
      crc_r           <= crc_nxt;
      temp_word_r     <= temp_word_nxt;
      hum_word_r      <= hum_word_nxt;
      temp_crc_good_r <= temp_crc_good_nxt;
      frm_valid_r     <= frm_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_r <= frm_nxt;
  end

endmodule

// File: rtl/hsfd_convert.sv
// three-stage conversion of raw words to centi units, status and result register
module hsfd_convert import hsfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         frm_valid,
  output logic         frm_ready,
  input  hsfd_frame_t  frm,
  input  hsfd_offset_t temp_offset,
  output logic         res_valid,
  input  logic         res_ready,
  output hsfd_centi_t  temperature_centi,
  output hsfd_centi_t  humidity_centi,
  output hsfd_status_t status
);

  localparam logic [30:0] TEMP_SPAN  = 31'd17500;
  localparam logic [29:0] HUM_SPAN   = 30'd12500;
  localparam logic [30:0] TEMP_BIAS  = 31'd32767;
  localparam logic [29:0] HUM_BIAS   = 30'd32767;
  localparam logic signed [15:0] TEMP_BASE = -16'sd4500;
  localparam logic signed [15:0] HUM_BASE  = -16'sd600;
  localparam logic signed [15:0] OFFSET_SCALE = 16'sd10;

  // stage a: scaled numerators
  logic        va_r;
  logic [30:0] num_t_r;
  logic [29:0] num_h_r;
  logic        tcrc_a_r, hcrc_a_r;
  // stage b: quotients by 65535
  logic        vb_r;
  logic [14:0] q_t_r;
  logic [13:0] q_h_r;
  logic        tcrc_b_r, hcrc_b_r;
  // result register
  logic         out_valid_r;
  hsfd_centi_t  temp_r, temp_nxt;
  hsfd_centi_t  hum_r, hum_nxt;
  hsfd_status_t status_r, status_nxt;

  logic a_free, b_free, c_free;
  logic [31:0] sum_t;
  logic [30:0] sum_h;
  logic signed [15:0] off_x10, t_wide, h_wide;

  assign c_free    = !out_valid_r || res_ready;
  assign b_free    = !vb_r || c_free;
  assign a_free    = !va_r || b_free;
  assign frm_ready = a_free;

  // floor(n / 65535) = (n + (n >> 16) + 1) >> 16 while the quotient stays below 2^16
  assign sum_t = {1'b0, num_t_r} + {17'd0, num_t_r[30:16]} + 32'd1;
  assign sum_h = {1'b0, num_h_r} + {17'd0, num_h_r[29:16]} + 31'd1;

  always_comb begin
    off_x10 = 16'(temp_offset) * OFFSET_SCALE;
    t_wide  = $signed({1'b0, q_t_r}) + TEMP_BASE + off_x10;
    h_wide  = $signed({2'b00, q_h_r}) + HUM_BASE;
    if (!tcrc_b_r) begin
      status_nxt = STATUS_TEMP_CRC;
    end else if (!hcrc_b_r) begin
      status_nxt = STATUS_HUM_CRC;
    end else if ((t_wide < TEMP_MIN) || (t_wide > TEMP_MAX)) begin
      status_nxt = STATUS_TEMP_RANGE;
    end else if ((h_wide < HUM_MIN) || (h_wide > HUM_MAX)) begin
      status_nxt = STATUS_HUM_RANGE;
    end else begin
      status_nxt = STATUS_OK;
    end
    temp_nxt = t_wide[14:0];
    hum_nxt  = h_wide[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_free) begin
        va_r <= frm_valid;
      end
      if (b_free) begin
        vb_r <= va_r;
      end
      if (c_free) begin
        out_valid_r <= vb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && frm_valid) begin
      num_t_r  <= 31'(frm.temp_word) * TEMP_SPAN + TEMP_BIAS;
      num_h_r  <= 30'(frm.hum_word) * HUM_SPAN + HUM_BIAS;
      tcrc_a_r <= frm.temp_crc_good;
      hcrc_a_r <= frm.hum_crc_good;
    end
    if (b_free && va_r) begin
      q_t_r    <= sum_t[30:16];
      q_h_r    <= sum_h[29:16];
      tcrc_b_r <= tcrc_a_r;
      hcrc_b_r <= hcrc_a_r;
    end
    if (c_free && vb_r) begin
      temp_r   <= temp_nxt;
      hum_r    <= hum_nxt;
      status_r <= status_nxt;
    end
  end

  assign res_valid         = out_valid_r;
  assign temperature_centi = temp_r;
  assign humidity_centi    = hum_r;
  assign status            = status_r;

endmodule

// File: rtl/hsfd_checker.sv
// port-level checks on the decoder result channel, bound to the top level
`include "humidity_sensor_frame_decoder_assert.svh"

module hsfd_checker import hsfd_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         out_valid,
  input logic         out_ready,
  input hsfd_centi_t  temperature_centi,
  input hsfd_centi_t  humidity_centi,
  input hsfd_status_t status
);

  logic signed [15:0] t_x, h_x;

  assign t_x = 16'(temperature_centi);
  assign h_x = 16'(humidity_centi);

  `HSFD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `HSFD_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable({temperature_centi, humidity_centi, status}), "result changed while stalled")
  `HSFD_ASSERT_IMP(a_status_code, out_valid, status <= STATUS_HUM_RANGE, "status code out of range")
  `HSFD_ASSERT_IMP(a_ok_in_range, out_valid && (status == STATUS_OK), (t_x >= TEMP_MIN) && (t_x <= TEMP_MAX) && (h_x >= HUM_MIN) && (h_x <= HUM_MAX), "ok status with value out of range")

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .temperature_centi (out_ch.temperature_centi),
  .humidity_centi    (out_ch.humidity_centi),
  .status            (out_ch.status)
);

// File: tb/testbench.sv
// self-checking testbench for the six-byte temperature/humidity frame decoder
`timescale 1ns / 1ps

module testbench;
  import hsfd_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 8;
  localparam int HOLD_TICKS   = 200;
  localparam int PHASE_BYTES  = 180;

  typedef struct {
    hsfd_byte_t rx;
    logic       start;
  } frame_byte_t;

  typedef struct {
    hsfd_centi_t  temp;
    hsfd_centi_t  hum;
    hsfd_status_t status;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n;

  hsfd_in_if  in_ch();
  hsfd_out_if out_ch();
  hsfd_cfg_if cfg_ch();

  humidity_sensor_frame_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  frame_byte_t byte_backlog[$];
  reading_t    readings_due[$];

  // decoder state as the block should hold it
  logic [2:0]   frame_pos   = 3'd0;
  hsfd_byte_t   crc_acc     = CRC_INIT;
  hsfd_word_t   temp_raw    = '0;
  hsfd_word_t   hum_raw     = '0;
  logic         temp_crc_ok = 1'b0;
  hsfd_offset_t offset_reg  = '0;

  int errors           = 0;
  int bytes_sent       = 0;
  int readings_checked = 0;
  int offsets_written  = 0;
  int status_seen[5]   = '{0, 0, 0, 0, 0};
  int quiet_cycles     = 0;

  bit in_offer;
  bit in_gaps_on  = 1'b1;
  int in_wait     = 0;
  bit out_gaps_on = 1'b1;
  int out_wait    = 0;
  int hold_left   = 0;

  // msb-first serial form of the crc-8, poly 0x31
  function automatic hsfd_byte_t sensor_crc8(hsfd_byte_t acc, hsfd_byte_t data);
    hsfd_byte_t r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // span*raw/65535 rounded to nearest
  function automatic int centi_scale(hsfd_word_t raw, int span);
    longint num;
    num = longint'(span) * longint'(raw) + 32767;
    return int'(num / 65535);
  endfunction

  function automatic void decode_byte(hsfd_byte_t b, logic start);
    logic [2:0] pos;
    int         t;
    int         h;
    reading_t   r;
    pos = start ? 3'd0 : frame_pos;
    if (pos > 3'd5) pos = 3'd0;
    case (pos)
      3'd0: begin
        temp_raw = {b, 8'h00};
        crc_acc = sensor_crc8(CRC_INIT, b);
      end
      3'd1: begin
        temp_raw[7:0] = b;
        crc_acc = sensor_crc8(crc_acc, b);
      end
      3'd2: temp_crc_ok = (crc_acc == b);
      3'd3: begin
        hum_raw = {b, 8'h00};
        crc_acc = sensor_crc8(CRC_INIT, b);
      end
      3'd4: begin
        hum_raw[7:0] = b;
        crc_acc = sensor_crc8(crc_acc, b);
      end
      default: begin
        t = -4500 + centi_scale(temp_raw, 17500) + 10 * int'(offset_reg);
        h = -600 + centi_scale(hum_raw, 12500);
        r.temp = hsfd_centi_t'(t);
        r.hum  = hsfd_centi_t'(h);
        if (!temp_crc_ok) r.status = STATUS_TEMP_CRC;
        else if (crc_acc != b) r.status = STATUS_HUM_CRC;
        else if (t < TEMP_MIN || t > TEMP_MAX) r.status = STATUS_TEMP_RANGE;
        else if (h < HUM_MIN || h > HUM_MAX) r.status = STATUS_HUM_RANGE;
        else r.status = STATUS_OK;
        readings_due.push_back(r);
      end
    endcase
    frame_pos = (pos >= 3'd5) ? 3'd0 : pos + 3'd1;
  endfunction

  function automatic void queue_byte(hsfd_byte_t b, logic start);
    frame_byte_t fb;
    fb.rx = b;
    fb.start = start;
    byte_backlog.push_back(fb);
  endfunction

  function automatic void queue_frame(hsfd_word_t tw, hsfd_word_t hw, logic mark,
                                      bit bad_temp, bit bad_hum);
    hsfd_byte_t tc;
    hsfd_byte_t hc;
    tc = sensor_crc8(sensor_crc8(CRC_INIT, tw[15:8]), tw[7:0]);
    hc = sensor_crc8(sensor_crc8(CRC_INIT, hw[15:8]), hw[7:0]);
    if (bad_temp) tc = tc ^ 8'($urandom_range(1, 255));
    if (bad_hum) hc = hc ^ 8'($urandom_range(1, 255));
    queue_byte(tw[15:8], mark);
    queue_byte(tw[7:0], 1'b0);
    queue_byte(tc, 1'b0);
    queue_byte(hw[15:8], 1'b0);
    queue_byte(hw[7:0], 1'b0);
    queue_byte(hc, 1'b0);
  endfunction

  // lean toward the ends of the scale so the range checks trip often
  function automatic hsfd_word_t pick_raw();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 4000));
      3: return 16'($urandom_range(54000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void queue_random_traffic(int n_bytes);
    int kind;
    int cut;
    while (n_bytes > 0) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        queue_frame(pick_raw(), pick_raw(), $urandom_range(0, 4) != 0,
                    $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0);
        n_bytes -= 6;
      end else if (kind < 90) begin
        // truncated frame, the next start mark throws it away
        cut = $urandom_range(1, 5);
        queue_frame(pick_raw(), pick_raw(), 1'b1, 1'b0, 1'b0);
        repeat (6 - cut) void'(byte_backlog.pop_back());
        n_bytes -= cut;
      end else begin
        queue_byte(8'($urandom), 1'($urandom));
        n_bytes -= 1;
      end
    end
  endfunction

  task automatic settle_block();
    while (byte_backlog.size() != 0 || readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_offset(hsfd_offset_t value);
    @(posedge clk);
    cfg_ch.temp_offset <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    offset_reg = value;
    cfg_ch.valid <= 1'b0;
    offsets_written++;
  endtask

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      in_offer = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.rx_byte, in_ch.frame_start);
        void'(byte_backlog.pop_front());
        bytes_sent++;
        in_offer = 1'b0;
        if ($urandom_range(0, 29) == 0) in_gaps_on = !in_gaps_on;
        in_wait = in_gaps_on ? $urandom_range(0, 9) : 0;
      end
      if (!in_offer) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (byte_backlog.size() != 0) begin
          in_offer = 1'b1;
          in_ch.rx_byte <= byte_backlog[0].rx;
          in_ch.frame_start <= byte_backlog[0].start;
        end
      end
      in_ch.valid <= in_offer;
    end
  end

  // reading monitor and checker
  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected reading temp %0d hum %0d status %0d", $time,
                   out_ch.temperature_centi, out_ch.humidity_centi, out_ch.status);
          errors++;
        end else begin
          want = readings_due.pop_front();
          if (want.status <= STATUS_HUM_RANGE) status_seen[want.status]++;
          if (out_ch.temperature_centi !== want.temp) begin
            $display("%0t: temperature_centi expected %0d got %0d", $time,
                     want.temp, out_ch.temperature_centi);
            errors++;
          end
          if (out_ch.humidity_centi !== want.hum) begin
            $display("%0t: humidity_centi expected %0d got %0d", $time,
                     want.hum, out_ch.humidity_centi);
            errors++;
          end
          if (out_ch.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_ch.status);
            errors++;
          end
        end
        readings_checked++;
        // long back-pressure so the block fills and stalls its byte input
        if (readings_checked == 40 || readings_checked == 120) hold_left = HOLD_TICKS;
        if ($urandom_range(0, 29) == 0) out_gaps_on = !out_gaps_on;
        out_wait = out_gaps_on ? $urandom_range(0, 9) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d readings outstanding", $time,
               quiet_cycles, readings_due.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int setting;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.temp_offset = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset offset
    queue_frame(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
    queue_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    queue_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b0);
    queue_byte(8'hA5, 1'b1);
    queue_frame(16'h6666, 16'h1000, 1'b1, 1'b0, 1'b1);
    settle_block();

    for (int k = 0; k < 6; k++) begin
      case (k)
        0: setting = 127;
        1: setting = -128;
        2: setting = 100;
        3: setting = -100;
        4: setting = int'($urandom_range(0, 200)) - 100;
        default: setting = 0;
      endcase
      write_offset(hsfd_offset_t'(setting));
      queue_random_traffic(PHASE_BYTES);
      settle_block();
    end

    $display("covered %0d bytes and %0d readings under %0d offset settings",
             bytes_sent, readings_checked, offsets_written + 1);
    $display("status mix: ok %0d, temp crc %0d, hum crc %0d, temp range %0d, hum range %0d",
             status_seen[STATUS_OK], status_seen[STATUS_TEMP_CRC], status_seen[STATUS_HUM_CRC],
             status_seen[STATUS_TEMP_RANGE], status_seen[STATUS_HUM_RANGE]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
